FILE: design/tsvf_pkg.sv
// Package with the word types, register indexes and character codes of the text formatter.
`timescale 1ns / 1ps
package tsvf_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       num;
		logic       pre;
		logic [7:0] pre_byte;
		logic [7:0] fin_byte;
	} job_ctl_t;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

	localparam logic [7:0] CHAR_TAB      = 8'd9;
	localparam logic [7:0] CHAR_NL       = 8'd10;
	localparam logic [7:0] CHAR_SPACE    = 8'd32;
	localparam logic [7:0] CHAR_DOLLAR   = 8'd36;
	localparam logic [7:0] CHAR_ZERO     = 8'd48;
	localparam logic [7:0] CHAR_QUESTION = 8'd63;
	localparam logic [7:0] CHAR_I        = 8'd73;
	localparam logic [7:0] CHAR_CARET    = 8'd94;
	localparam logic [7:0] CHAR_DEL      = 8'd127;
	localparam logic [7:0] CARET_OFFSET  = 8'd64;

	localparam int JOBQ_DEPTH = 4;

endpackage

FILE: design/text_stream_visible_formatter.sv
// Top level of the text formatter: front end, job queue and back end.
//
// The formatter takes one text byte per word and gives the formatted bytes, the final one of
// each input marked by last. The front end takes a byte whenever the queue has room and queues
// a job; the back end sends one output word per cycle while a job waits and the output register
// is empty or popped. A byte gives one word if plain, two for a caret or dollar form, and
// NUMBER_DIGITS + 1 more when a line number leads it. A squeezed newline gives no words or job.
// The job queue is four jobs deep, so the input keeps flowing while output words wait to be
// popped. Configuration writes are always ready and are meant for times when no job is pending.
`timescale 1ns / 1ps
module text_stream_visible_formatter #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  tsvf_pkg::item_t                   item,
	output logic                              empty,
	input  logic                              pop,
	output tsvf_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsvf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic                              cfg_data
);
	import tsvf_pkg::*;

	localparam int NW = 4 * NUMBER_DIGITS;
	localparam int JW = $bits(job_ctl_t) + NW + NUMBER_DIGITS;

	logic                     accept;
	logic                     job_push;
	logic                     job_pop;
	logic                     job_valid;
	logic                     jobq_full;
	job_ctl_t                 push_ctl;
	logic [NW-1:0]            push_number;
	logic [NUMBER_DIGITS-1:0] push_blank;
	job_ctl_t                 head_ctl;
	logic [NW-1:0]            head_number;
	logic [NUMBER_DIGITS-1:0] head_blank;
	logic [JW-1:0]            head_job;

	assign cfg_ready = 1'b1;
	assign full      = jobq_full;
	assign accept    = push && !jobq_full;

	tsvf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.cfg_write  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.job_push   (job_push),
		.job_ctl    (push_ctl),
		.job_number (push_number),
		.job_blank  (push_blank)
	);

	tsvf_jobq #(
		.WIDTH(JW),
		.DEPTH(JOBQ_DEPTH)
	) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data ({push_ctl, push_number, push_blank}),
		.rd_en   (job_pop),
		.rd_data (head_job),
		.valid   (job_valid),
		.full    (jobq_full)
	);

	assign {head_ctl, head_number, head_blank} = head_job;

	tsvf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_ctl    (head_ctl),
		.job_number (head_number),
		.job_blank  (head_blank),
		.job_pop    (job_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

	// The back end retires a job only while one is at the head of the queue.
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job retired from an empty queue");

	// A job is queued only when there is room for it.
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !jobq_full)
		else $error("job queued into a full queue");

	// A waiting word that is not the last of its input leaves its job at the queue head.
	a_partial_keeps_job: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last) |-> job_valid)
		else $error("job retired before its last word was sent");

endmodule

FILE: design/tsvf_front.sv
// Front end: configuration registers, squeeze and numbering decisions, line counter.
`timescale 1ns / 1ps
module tsvf_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  tsvf_pkg::item_t                     item,
	input  logic                                cfg_write,
	input  logic [tsvf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic                                cfg_data,
	output logic                                job_push,
	output tsvf_pkg::job_ctl_t                  job_ctl,
	output logic [4*NUMBER_DIGITS-1:0]          job_number,
	output logic [NUMBER_DIGITS-1:0]            job_blank
);
	import tsvf_pkg::*;

	localparam int NW = 4 * NUMBER_DIGITS;
	localparam logic [NW-1:0] NUMBER_ONE = NW'(1);

	logic          number_nonblank_q;
	logic          number_all_q;
	logic          squeeze_blank_q;
	logic          show_tabs_q;
	logic          show_ends_q;
	logic          show_nonprinting_q;

	logic [NW-1:0] number_q;
	logic [1:0]    run_q;
	logic          at_line_start_q;

	logic          eff_ls;
	logic [1:0]    eff_run;
	logic [1:0]    new_run;
	logic          is_nl;
	logic          is_tab;
	logic          squeezed;
	logic          num_now;
	logic [NW-1:0] number_inc;
	logic          all_nines;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_nonblank_q  <= 1'b0;
			number_all_q       <= 1'b0;
			squeeze_blank_q    <= 1'b0;
			show_tabs_q        <= 1'b0;
			show_ends_q        <= 1'b0;
			show_nonprinting_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_NUMBER_NONBLANK:  number_nonblank_q  <= cfg_data;
				CFG_NUMBER_ALL:       number_all_q       <= cfg_data;
				CFG_SQUEEZE_BLANK:    squeeze_blank_q    <= cfg_data;
				CFG_SHOW_TABS:        show_tabs_q        <= cfg_data;
				CFG_SHOW_ENDS:        show_ends_q        <= cfg_data;
				CFG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_ls  = item.file_start | at_line_start_q;
		eff_run = item.file_start ? 2'd0 : run_q;
		is_nl   = item.in_byte == CHAR_NL;
		is_tab  = item.in_byte == CHAR_TAB;
		new_run = eff_run;
		if (squeeze_blank_q) begin
			if (is_nl && eff_ls) begin
				new_run = (eff_run == 2'd2) ? 2'd2 : eff_run + 2'd1;
			end else begin
				new_run = 2'd0;
			end
		end
		squeezed = squeeze_blank_q && (new_run == 2'd2);
		if (number_nonblank_q) begin
			num_now = eff_ls && !is_nl;
		end else begin
			num_now = number_all_q && eff_ls;
		end
	end

	always_comb begin
		job_ctl.num      = num_now;
		job_ctl.pre      = 1'b0;
		job_ctl.pre_byte = CHAR_CARET;
		job_ctl.fin_byte = item.in_byte;
		if (show_tabs_q && is_tab) begin
			job_ctl.pre      = 1'b1;
			job_ctl.fin_byte = CHAR_I;
		end else if (show_ends_q && is_nl) begin
			job_ctl.pre      = 1'b1;
			job_ctl.pre_byte = CHAR_DOLLAR;
		end else if (show_nonprinting_q && (item.in_byte < CHAR_TAB
				|| (item.in_byte > CHAR_NL && item.in_byte < CHAR_SPACE))) begin
			job_ctl.pre      = 1'b1;
			job_ctl.fin_byte = item.in_byte + CARET_OFFSET;
		end else if (show_nonprinting_q && item.in_byte == CHAR_DEL) begin
			job_ctl.pre      = 1'b1;
			job_ctl.fin_byte = CHAR_QUESTION;
		end
	end

	// Increment with carry through digits at nine; the counter holds at all nines.
	always_comb begin
		logic       carry;
		logic [3:0] dig;
		carry      = 1'b1;
		all_nines  = 1'b1;
		number_inc = number_q;
		for (int d = 0; d < NUMBER_DIGITS; d++) begin
			dig = number_q[4*d +: 4];
			if (dig != 4'd9) begin
				all_nines = 1'b0;
			end
			if (carry) begin
				number_inc[4*d +: 4] = (dig >= 4'd9) ? 4'd0 : dig + 4'd1;
			end
			carry = carry && (dig >= 4'd9);
		end
	end

	// A digit prints as a space while it and every higher digit are zero, except the lowest digit.
	always_comb begin
		logic hi_zero;
		hi_zero = 1'b1;
		for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
			hi_zero      = hi_zero && (number_q[4*d +: 4] == 4'd0);
			job_blank[d] = hi_zero && (d != 0);
		end
	end

	assign job_number = number_q;
	assign job_push   = accept && !squeezed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_q        <= NUMBER_ONE;
			run_q           <= 2'd0;
			at_line_start_q <= 1'b1;
		end else if (accept) begin
			run_q           <= new_run;
			at_line_start_q <= is_nl;
			if (num_now && !squeezed && !all_nines) begin
				number_q <= number_inc;
			end
		end
	end

endmodule

FILE: design/tsvf_jobq.sv
// Short first-in first-out queue of decoded jobs between the front and back ends.
`timescale 1ns / 1ps
module tsvf_jobq #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             valid,
	output logic             full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign valid   = count_q != '0;
	assign full    = count_q == CW'(DEPTH);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/tsvf_back.sv
// Back end: walks each job, sending its output words through an output register one per cycle unless held.
`timescale 1ns / 1ps
module tsvf_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  tsvf_pkg::job_ctl_t           job_ctl,
	input  logic [4*NUMBER_DIGITS-1:0]   job_number,
	input  logic [NUMBER_DIGITS-1:0]     job_blank,
	output logic                         job_pop,
	output tsvf_pkg::result_t            result,
	output logic                         empty,
	input  logic                         pop
);
	import tsvf_pkg::*;

	localparam int SW = $clog2(NUMBER_DIGITS + 3);
	localparam logic [SW-1:0] STEP_TAB = SW'(NUMBER_DIGITS);
	localparam logic [SW-1:0] STEP_PRE = SW'(NUMBER_DIGITS + 1);
	localparam logic [SW-1:0] STEP_FIN = SW'(NUMBER_DIGITS + 2);

	logic          active_q;
	logic [SW-1:0] step_q;
	logic          out_valid_q;
	result_t       result_q;

	logic [SW-1:0] step;
	logic [SW-1:0] next_step;
	logic [3:0]    digit;
	logic          digit_blank;
	logic [7:0]    cur_byte;
	logic          is_final;
	logic          emit;

	always_comb begin
		if (active_q) begin
			step = step_q;
		end else if (job_ctl.num) begin
			step = '0;
		end else if (job_ctl.pre) begin
			step = STEP_PRE;
		end else begin
			step = STEP_FIN;
		end
	end

	// The most significant digit comes out first.
	always_comb begin
		digit       = job_number[3:0];
		digit_blank = job_blank[0];
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (step == SW'(NUMBER_DIGITS - 1 - i)) begin
				digit       = job_number[4*i +: 4];
				digit_blank = job_blank[i];
			end
		end
	end

	always_comb begin
		is_final  = 1'b0;
		next_step = step + 1'b1;
		if (step == STEP_TAB) begin
			cur_byte  = CHAR_TAB;
			next_step = job_ctl.pre ? STEP_PRE : STEP_FIN;
		end else if (step == STEP_PRE) begin
			cur_byte = job_ctl.pre_byte;
		end else if (step == STEP_FIN) begin
			cur_byte = job_ctl.fin_byte;
			is_final = 1'b1;
		end else begin
			cur_byte = digit_blank ? CHAR_SPACE : CHAR_ZERO + {4'd0, digit};
		end
	end

	assign emit    = job_valid && (!out_valid_q || pop);
	assign job_pop = emit && is_final;
	assign empty   = !out_valid_q;
	assign result  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				active_q    <= !is_final;
				step_q      <= next_step;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.out_byte <= cur_byte;
			result_q.last     <= is_final;
		end
	end

endmodule
